@@ rtl/ssc_pkg.sv @@
// Shared types, constants and bit-manipulation helpers for the spin state
// canonical representative unit. No dependencies.
package ssc_pkg;

   localparam int MaxSites  = 32;
   localparam int NumFam    = 4;
   localparam int NumShift  = MaxSites / 2 + 1;
   localparam int NumCand   = NumFam * NumShift;
   localparam int CodeWidth = 3;
   localparam int NumCodes  = 7;
   localparam int ShiftWidth = 5;
   localparam int CsrWidth  = 6;
   localparam logic [CsrWidth-1:0] ChainLenReset = 6'd16;
   localparam logic [CsrWidth-1:0] ChainLenMin   = 6'd8;
   localparam logic [CsrWidth-1:0] ChainLenMax   = 6'd32;

   // one candidate word with its symmetry tag
   typedef struct packed {
      logic                  valid;
      logic [MaxSites-1:0]   word;
      logic [ShiftWidth-1:0] shift;
      logic                  refl;
      logic                  inv;
   } ssc_cand_type;

   // site count for a length code: code 0 is 8 sites, code 6 is 32 sites
   function automatic int site_count(input int code);
      return 4 * (code + 2);
   endfunction

   function automatic logic [MaxSites-1:0] site_mask(input int nn);
      logic [MaxSites-1:0] m;
      m = '0;
      for (int j = 0; j < MaxSites; j++) begin
         if (j < nn) m[j] = 1'b1;
      end
      return m;
   endfunction

   // reverse the low nn sites
   function automatic logic [MaxSites-1:0] reverse_sites(input logic [MaxSites-1:0] w,
                                                         input int nn);
      logic [MaxSites-1:0] r;
      r = '0;
      for (int j = 0; j < MaxSites; j++) begin
         if (j < nn) r[nn-1-j] = w[j];
      end
      return r;
   endfunction

   // rotate the low nn sites by amt places toward higher positions
   function automatic logic [MaxSites-1:0] rotate_sites(input logic [MaxSites-1:0] w,
                                                        input int amt, input int nn);
      logic [MaxSites-1:0] r;
      int k;
      r = '0;
      if (amt <= nn) begin
         for (int j = 0; j < MaxSites; j++) begin
            if (j < nn) begin
               k = j + amt;
               if (k >= nn) k = k - nn;
               r[k[4:0]] = w[j];
            end
         end
      end
      return r;
   endfunction

   // a is earlier in search order; b wins only when valid and a is invalid or b is strictly smaller
   function automatic ssc_cand_type pick(input ssc_cand_type a, input ssc_cand_type b);
      if (b.valid && (!a.valid || (b.word < a.word))) return b;
      return a;
   endfunction

endpackage

@@ rtl/spin_state_canonical_representative_unit.sv @@
// A request passes through five register stages: base words, rotations and
// three minimum-tree stages. Throughput: one request per cycle while
// rsp_tready allows; every stage has its own valid bit and takes a new
// request whenever it is empty or its successor moves.
// Reset (synchronous, active high) empties the pipeline and sets chain_length to 16.
// Top level: ties ssc_base, ssc_cand and ssc_tree together; uses ssc_pkg.
module spin_state_canonical_representative_unit (
   input  logic        clock,
   input  logic        reset,
   // request: state_word[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: representative[31:0], shift_count[36:32], reflected[37],
   // inverted[38], zero pad[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // chain_length register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);

   logic [ssc_pkg::CsrWidth-1:0]  chain_len_ff;
   logic [ssc_pkg::CsrWidth-1:0]  chain_len_sat;
   logic [ssc_pkg::CodeWidth-1:0] site_code;

   logic                          base_valid, base_ready;
   logic [ssc_pkg::MaxSites-1:0]  base_word [ssc_pkg::NumFam];
   logic [ssc_pkg::CodeWidth-1:0] base_code;
   logic                          cand_valid, cand_ready;
   ssc_pkg::ssc_cand_type         cand [ssc_pkg::NumCand];
   ssc_pkg::ssc_cand_type         best;

   // config register; always writable; the user must change it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_len_ff <= ssc_pkg::ChainLenReset;
      end else if (csr_valid) begin
         chain_len_ff <= csr_data;
      end
   end

   // clamp to 8..32 sites, round down to a multiple of four, code = n/4 - 2
   always_comb begin
      chain_len_sat = chain_len_ff;
      if (chain_len_ff < ssc_pkg::ChainLenMin) chain_len_sat = ssc_pkg::ChainLenMin;
      if (chain_len_ff > ssc_pkg::ChainLenMax) chain_len_sat = ssc_pkg::ChainLenMax;
      site_code = chain_len_sat[4:2] - 3'd2;
      if (chain_len_sat[5]) site_code = 3'd6;
   end

   ssc_base u_base (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .state_word (req_tdata),
      .site_code  (site_code),
      .out_valid  (base_valid),
      .out_ready  (base_ready),
      .base_ff    (base_word),
      .code_ff    (base_code)
   );

   ssc_cand u_cand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (base_valid),
      .in_ready  (base_ready),
      .base      (base_word),
      .site_code (base_code),
      .out_valid (cand_valid),
      .out_ready (cand_ready),
      .cand_ff   (cand)
   );

   ssc_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cand_valid),
      .in_ready  (cand_ready),
      .cand      (cand),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .best_ff   (best)
   );

   assign rsp_tdata = {1'b0, best.inv, best.refl, best.shift, best.word};

endmodule

@@ rtl/ssc_base.sv @@
// Stage 1: masks the incoming word to the ring length and forms the four
// base words (plain, reversed, inverted, inverted reversed). Uses ssc_pkg.
module ssc_base (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ssc_pkg::MaxSites-1:0]   state_word,
   input  logic [ssc_pkg::CodeWidth-1:0]  site_code,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [ssc_pkg::MaxSites-1:0]   base_ff [ssc_pkg::NumFam],
   output logic [ssc_pkg::CodeWidth-1:0]  code_ff
);

   logic                         valid_ff;
   logic [ssc_pkg::MaxSites-1:0] mask;
   logic [ssc_pkg::MaxSites-1:0] masked;
   logic [ssc_pkg::MaxSites-1:0] rev;
   logic [ssc_pkg::MaxSites-1:0] base_in [ssc_pkg::NumFam];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_comb begin
      mask   = '0;
      masked = '0;
      rev    = '0;
      for (int c = 0; c < ssc_pkg::NumCodes; c++) begin
         if (site_code == ssc_pkg::CodeWidth'(c)) begin
            mask   = ssc_pkg::site_mask(ssc_pkg::site_count(c));
            masked = state_word & mask;
            rev    = ssc_pkg::reverse_sites(masked, ssc_pkg::site_count(c));
         end
      end
      base_in[0] = masked;
      base_in[1] = rev;
      base_in[2] = ~masked & mask;
      base_in[3] = ~rev & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         base_ff <= base_in;
         code_ff <= site_code;
      end
   end

endmodule

@@ rtl/ssc_cand.sv @@
// Stage 2: expands each base word into every two-site rotation, tagging each
// candidate with its rotation count and symmetry flags. Uses ssc_pkg.
module ssc_cand (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [ssc_pkg::MaxSites-1:0]        base [ssc_pkg::NumFam],
   input  logic [ssc_pkg::CodeWidth-1:0]       site_code,
   output logic                                out_valid,
   input  logic                                out_ready,
   output ssc_pkg::ssc_cand_type               cand_ff [ssc_pkg::NumCand]
);

   logic                  valid_ff;
   ssc_pkg::ssc_cand_type cand_in [ssc_pkg::NumCand];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   // candidate order: family major, rotation minor; valid while twice the index is at most the ring length
   always_comb begin
      for (int f = 0; f < ssc_pkg::NumFam; f++) begin
         for (int i = 0; i < ssc_pkg::NumShift; i++) begin
            cand_in[f*ssc_pkg::NumShift+i].valid = 1'b0;
            cand_in[f*ssc_pkg::NumShift+i].word  = '0;
            cand_in[f*ssc_pkg::NumShift+i].shift = ssc_pkg::ShiftWidth'(i);
            cand_in[f*ssc_pkg::NumShift+i].refl  = (f == 1) || (f == 3);
            cand_in[f*ssc_pkg::NumShift+i].inv   = (f >= 2);
            for (int c = 0; c < ssc_pkg::NumCodes; c++) begin
               if (site_code == ssc_pkg::CodeWidth'(c)) begin
                  cand_in[f*ssc_pkg::NumShift+i].valid = (2 * i <= ssc_pkg::site_count(c));
                  cand_in[f*ssc_pkg::NumShift+i].word  =
                     ssc_pkg::rotate_sites(base[f], 2 * i, ssc_pkg::site_count(c));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cand_ff <= cand_in;
      end
   end

endmodule

@@ rtl/ssc_tree.sv @@
// Stages 3 to 5: registered minimum tree over all candidates, earlier
// candidate kept on ties. Uses ssc_pkg.
module ssc_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ssc_pkg::ssc_cand_type cand [ssc_pkg::NumCand],
   output logic                  out_valid,
   input  logic                  out_ready,
   output ssc_pkg::ssc_cand_type best_ff
);

   logic                  v3_ff, v4_ff, v5_ff;
   logic                  rdy3, rdy4, rdy5;
   ssc_pkg::ssc_cand_type lvl1 [34];
   ssc_pkg::ssc_cand_type lvl2 [17];
   ssc_pkg::ssc_cand_type t3_ff [17];
   ssc_pkg::ssc_cand_type lvl3 [9];
   ssc_pkg::ssc_cand_type lvl4 [5];
   ssc_pkg::ssc_cand_type t4_ff [5];
   ssc_pkg::ssc_cand_type lvl5 [3];
   ssc_pkg::ssc_cand_type lvl6 [2];
   ssc_pkg::ssc_cand_type best_in;

   assign rdy5      = !v5_ff || out_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign in_ready  = rdy3;
   assign out_valid = v5_ff;

   // 68 -> 34 -> 17
   always_comb begin
      for (int k = 0; k < 34; k++) lvl1[k] = ssc_pkg::pick(cand[2*k], cand[2*k+1]);
      for (int k = 0; k < 17; k++) lvl2[k] = ssc_pkg::pick(lvl1[2*k], lvl1[2*k+1]);
   end

   // 17 -> 9 -> 5, odd leftover passes through
   always_comb begin
      for (int k = 0; k < 8; k++) lvl3[k] = ssc_pkg::pick(t3_ff[2*k], t3_ff[2*k+1]);
      lvl3[8] = t3_ff[16];
      for (int k = 0; k < 4; k++) lvl4[k] = ssc_pkg::pick(lvl3[2*k], lvl3[2*k+1]);
      lvl4[4] = lvl3[8];
   end

   // 5 -> 3 -> 2 -> 1
   always_comb begin
      lvl5[0] = ssc_pkg::pick(t4_ff[0], t4_ff[1]);
      lvl5[1] = ssc_pkg::pick(t4_ff[2], t4_ff[3]);
      lvl5[2] = t4_ff[4];
      lvl6[0] = ssc_pkg::pick(lvl5[0], lvl5[1]);
      lvl6[1] = lvl5[2];
      best_in = ssc_pkg::pick(lvl6[0], lvl6[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy3) v3_ff <= in_valid;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && in_valid) t3_ff   <= lvl2;
      if (rdy4 && v3_ff)    t4_ff   <= lvl4;
      if (rdy5 && v4_ff)    best_ff <= best_in;
   end

endmodule
